// ===== src/array_list_engine_macros.svh =====
// Assertion macros for the array list engine.
// Used by the top level only; depends on nothing else.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ALE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array_list_engine: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ALE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array_list_engine: assertion failed");
`else
`define ALE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ALE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ale_pkg.sv =====
// Shared constants and types for the array list engine.
// Depends on nothing; used by the divider and the top level.
`timescale 1ns / 1ps

package ale_pkg;

    // Store geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Command codes.
    localparam logic [3:0] CMD_CLEAR   = 4'd0;
    localparam logic [3:0] CMD_APPEND  = 4'd1;
    localparam logic [3:0] CMD_INSERT  = 4'd2;
    localparam logic [3:0] CMD_DELETE  = 4'd3;
    localparam logic [3:0] CMD_GET     = 4'd4;
    localparam logic [3:0] CMD_SEARCH  = 4'd5;
    localparam logic [3:0] CMD_TSEARCH = 4'd6;
    localparam logic [3:0] CMD_MIN     = 4'd7;
    localparam logic [3:0] CMD_MAX     = 4'd8;
    localparam logic [3:0] CMD_SUM     = 4'd9;
    localparam logic [3:0] CMD_AVG     = 4'd10;
    localparam logic [3:0] CMD_REVERSE = 4'd11;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADIDX   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHUP,
        S_SHDN,
        S_SWP1,
        S_SWP2,
        S_GET,
        S_GETD,
        S_REVA,
        S_REVB,
        S_REVC,
        S_REVD,
        S_DIVW,
        S_FIN
    } state_t;

endpackage

// ===== src/ale_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/ale_div.sv =====
// Restoring divider, one quotient bit per cycle, for the average command.
// Depends on ale_pkg.
`timescale 1ns / 1ps

module ale_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ale_pkg::WORD_W-1:0]       dividend,
    input  logic [ale_pkg::CNT_W-1:0]        divisor,
    output logic                             done,
    output logic [ale_pkg::WORD_W-1:0]       quotient
);

    localparam int STEP_W = $clog2(ale_pkg::WORD_W);

    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [ale_pkg::WORD_W-1:0]  dvd_reg, dvd_next;
    logic [ale_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [ale_pkg::CNT_W-1:0]   dsr_reg, dsr_next;
    logic [ale_pkg::CNT_W:0]     trial;
    logic                        qbit;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[ale_pkg::WORD_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (run_reg)
        begin
            rem_next  = qbit ? ale_pkg::CNT_W'(trial - {1'b0, dsr_reg})
                             : trial[ale_pkg::CNT_W-1:0];
            dvd_next  = {dvd_reg[ale_pkg::WORD_W-2:0], qbit};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ale_pkg::WORD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== src/array_list_engine.sv =====
// Array list engine: one command per transfer, one result transfer per command.
// Search and reductions walk the list, insert and delete walk the tail they shift, and
// reverse swaps pairs from both ends, all through the single RAM port; average then
// waits on the bit-serial divider.
// Throughput: one command at a time. Reset empties the list and sets capacity to 64;
// the word RAM itself is not cleared.
`timescale 1ns / 1ps
`include "array_list_engine_macros.svh"

module array_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ale_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [3:0]                        cmd,
    input  logic [ale_pkg::CNT_W-1:0]         position,
    input  logic signed [ale_pkg::WORD_W-1:0] word_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ale_pkg::WORD_W-1:0] word_out,
    output logic [ale_pkg::ADDR_W-1:0]        found_at,
    output logic [2:0]                        status,
    output logic [ale_pkg::CNT_W-1:0]         element_count
);

    localparam int AW = ale_pkg::ADDR_W;
    localparam int CW = ale_pkg::CNT_W;
    localparam int WW = ale_pkg::WORD_W;

    ale_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] cap_reg;
    logic [3:0]    cmd_reg, cmd_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [WW-1:0] word_reg, word_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          iss_reg, iss_next;
    logic [WW-1:0] acc_reg, acc_next;
    logic [WW-1:0] prev_reg, prev_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic [WW-1:0] res_word_reg, res_word_next;
    logic [AW-1:0] res_found_reg, res_found_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic          out_vld_reg, out_vld_next;
    logic [WW-1:0] out_word_reg;
    logic [AW-1:0] out_found_reg;
    logic [2:0]    out_status_reg;
    logic [CW-1:0] out_cnt_reg;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;

    logic          div_start;
    logic          div_done;
    logic [WW-1:0] div_quot;
    logic [WW-1:0] acc_mag;

    logic          accept, full, out_free, walk_done, hit, is_search;
    logic [CW-1:0] eff_cap, cnt_m1, rd_idx_p1, rd_idx_m1, idx_p1, idx_m1, hi_m1;

    // Handshake and derived conditions.
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ale_pkg::S_IDLE);
    assign out_free  = !out_vld_reg || !out_stall;
    assign eff_cap   = (cap_reg == '0) ? CW'(1)
                     : ((cap_reg > CW'(ale_pkg::DEPTH)) ? CW'(ale_pkg::DEPTH) : cap_reg);
    assign full      = (cnt_reg >= eff_cap);
    assign cnt_m1    = cnt_reg - CW'(1);
    assign rd_idx_p1 = rd_idx_reg + CW'(1);
    assign rd_idx_m1 = rd_idx_reg - CW'(1);
    assign idx_p1    = idx_reg + CW'(1);
    assign idx_m1    = idx_reg - CW'(1);
    assign hi_m1     = hi_reg - CW'(1);
    assign walk_done = !iss_reg && !rd_vld_reg;
    assign hit       = rd_vld_reg && (ram_rdata == word_reg);
    assign is_search = (cmd_reg == ale_pkg::CMD_SEARCH) || (cmd_reg == ale_pkg::CMD_TSEARCH);
    assign acc_mag   = acc_reg[WW-1] ? (~acc_reg + WW'(1)) : acc_reg;

    // Word store.
    ale_ram #(
        .WIDTH (WW),
        .DEPTH (ale_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Divider for the average.
    ale_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_mag),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd) inside
                        ale_pkg::CMD_INSERT:
                            state_next = (position < cnt_reg && !full)
                                       ? ale_pkg::S_SHUP : ale_pkg::S_FIN;
                        ale_pkg::CMD_DELETE:
                            state_next = (cnt_reg != '0 && position < cnt_m1)
                                       ? ale_pkg::S_SHDN : ale_pkg::S_FIN;
                        ale_pkg::CMD_GET:
                            state_next = (position < cnt_reg) ? ale_pkg::S_GET : ale_pkg::S_FIN;
                        ale_pkg::CMD_SEARCH, ale_pkg::CMD_TSEARCH, ale_pkg::CMD_MIN,
                        ale_pkg::CMD_MAX, ale_pkg::CMD_SUM, ale_pkg::CMD_AVG:
                            state_next = (cnt_reg != '0) ? ale_pkg::S_SCAN : ale_pkg::S_FIN;
                        ale_pkg::CMD_REVERSE:
                            state_next = (cnt_reg > CW'(1)) ? ale_pkg::S_REVA : ale_pkg::S_FIN;
                        default:
                            state_next = ale_pkg::S_FIN;
                    endcase
                end
            end
            ale_pkg::S_SCAN:
            begin
                if (is_search && hit)
                begin
                    state_next = (cmd_reg == ale_pkg::CMD_TSEARCH && rd_idx_reg != '0)
                               ? ale_pkg::S_SWP1 : ale_pkg::S_FIN;
                end
                else if (walk_done)
                begin
                    state_next = (cmd_reg == ale_pkg::CMD_AVG) ? ale_pkg::S_DIVW : ale_pkg::S_FIN;
                end
            end
            ale_pkg::S_SHUP, ale_pkg::S_SHDN:
            begin
                if (walk_done)
                begin
                    state_next = ale_pkg::S_FIN;
                end
            end
            ale_pkg::S_SWP1: state_next = ale_pkg::S_SWP2;
            ale_pkg::S_SWP2: state_next = ale_pkg::S_FIN;
            ale_pkg::S_GET:  state_next = ale_pkg::S_GETD;
            ale_pkg::S_GETD: state_next = ale_pkg::S_FIN;
            ale_pkg::S_REVA: state_next = ale_pkg::S_REVB;
            ale_pkg::S_REVB: state_next = ale_pkg::S_REVC;
            ale_pkg::S_REVC: state_next = ale_pkg::S_REVD;
            ale_pkg::S_REVD:
                state_next = (idx_p1 < hi_m1) ? ale_pkg::S_REVA : ale_pkg::S_FIN;
            ale_pkg::S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = ale_pkg::S_FIN;
                end
            end
            ale_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = ale_pkg::S_IDLE;
                end
            end
            default: state_next = ale_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        idx_next        = idx_reg;
        hi_next         = hi_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = 1'b0;
        iss_next        = iss_reg;
        acc_next        = acc_reg;
        prev_next       = prev_reg;
        hit_next        = hit_reg;
        res_word_next   = res_word_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[AW-1:0];
        ram_wdata       = word_reg;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[AW-1:0];
        div_start       = 1'b0;
        unique case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd;
                    pos_next        = position;
                    word_next       = word_in;
                    res_word_next   = '0;
                    res_found_next  = '0;
                    res_status_next = ale_pkg::ST_OK;
                    acc_next        = '0;
                    iss_next        = 1'b1;
                    idx_next        = '0;
                    unique case (cmd) inside
                        ale_pkg::CMD_CLEAR:
                            cnt_next = '0;
                        ale_pkg::CMD_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = ale_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[AW-1:0];
                                ram_wdata = word_in;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        ale_pkg::CMD_INSERT:
                        begin
                            ram_waddr = position[AW-1:0];
                            ram_wdata = word_in;
                            if (position > cnt_reg)
                            begin
                                res_status_next = ale_pkg::ST_BADIDX;
                            end
                            else if (full)
                            begin
                                if (position < cnt_reg)
                                begin
                                    ram_we          = 1'b1;
                                    res_status_next = ale_pkg::ST_FULL;
                                end
                                else
                                begin
                                    res_status_next = ale_pkg::ST_BADIDX;
                                end
                            end
                            else if (position == cnt_reg)
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            else
                            begin
                                idx_next = cnt_m1;
                            end
                        end
                        ale_pkg::CMD_DELETE:
                        begin
                            if (position >= cnt_reg)
                            begin
                                res_status_next = ale_pkg::ST_BADIDX;
                            end
                            else if (position == cnt_m1)
                            begin
                                cnt_next = cnt_m1;
                            end
                            else
                            begin
                                idx_next = position + CW'(1);
                            end
                        end
                        ale_pkg::CMD_GET:
                        begin
                            if (position >= cnt_reg)
                            begin
                                res_status_next = ale_pkg::ST_BADIDX;
                            end
                        end
                        ale_pkg::CMD_SEARCH, ale_pkg::CMD_TSEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ale_pkg::ST_NOTFOUND;
                            end
                        end
                        ale_pkg::CMD_MIN, ale_pkg::CMD_MAX, ale_pkg::CMD_AVG:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ale_pkg::ST_EMPTY;
                            end
                        end
                        ale_pkg::CMD_REVERSE:
                            hi_next = cnt_m1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            // Ascending walk over the list, one read a cycle.
            ale_pkg::S_SCAN:
            begin
                if (iss_reg)
                begin
                    ram_re   = 1'b1;
                    iss_next = (idx_reg != cnt_m1);
                    idx_next = idx_p1;
                end
                rd_vld_next = iss_reg;
                rd_idx_next = idx_reg;
                if (rd_vld_reg)
                begin
                    if (!hit)
                    begin
                        prev_next = ram_rdata;
                    end
                    unique case (cmd_reg) inside
                        ale_pkg::CMD_MIN:
                            if (rd_idx_reg == '0 || $signed(ram_rdata) < $signed(acc_reg))
                            begin
                                acc_next = ram_rdata;
                            end
                        ale_pkg::CMD_MAX:
                            if (rd_idx_reg == '0 || $signed(ram_rdata) > $signed(acc_reg))
                            begin
                                acc_next = ram_rdata;
                            end
                        ale_pkg::CMD_SUM, ale_pkg::CMD_AVG:
                            acc_next = acc_reg + ram_rdata;
                        default:
                        begin
                        end
                    endcase
                end
                if (is_search && hit)
                begin
                    res_found_next = rd_idx_reg[AW-1:0];
                    hit_next       = rd_idx_reg[AW-1:0];
                end
                else if (walk_done)
                begin
                    unique case (cmd_reg) inside
                        ale_pkg::CMD_SEARCH, ale_pkg::CMD_TSEARCH:
                            res_status_next = ale_pkg::ST_NOTFOUND;
                        ale_pkg::CMD_AVG:
                            div_start = 1'b1;
                        default:
                            res_word_next = acc_reg;
                    endcase
                end
            end
            // Tail shift up: each word moves to the next higher index.
            ale_pkg::S_SHUP:
            begin
                if (iss_reg)
                begin
                    ram_re   = 1'b1;
                    iss_next = (idx_reg != pos_reg);
                    idx_next = idx_m1;
                end
                rd_vld_next = iss_reg;
                rd_idx_next = idx_reg;
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_p1[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                else if (walk_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg[AW-1:0];
                    ram_wdata = word_reg;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            // Tail shift down: each word moves to the next lower index.
            ale_pkg::S_SHDN:
            begin
                if (iss_reg)
                begin
                    ram_re   = 1'b1;
                    iss_next = (idx_reg != cnt_m1);
                    idx_next = idx_p1;
                end
                rd_vld_next = iss_reg;
                rd_idx_next = idx_reg;
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_m1[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                else if (walk_done)
                begin
                    cnt_next = cnt_m1;
                end
            end
            // Transposition: the hit trades places with its predecessor.
            ale_pkg::S_SWP1:
            begin
                ram_we    = 1'b1;
                ram_waddr = hit_reg;
                ram_wdata = prev_reg;
            end
            ale_pkg::S_SWP2:
            begin
                ram_we         = 1'b1;
                ram_waddr      = hit_reg - AW'(1);
                ram_wdata      = word_reg;
                res_found_next = hit_reg - AW'(1);
            end
            ale_pkg::S_GET:
            begin
                ram_re    = 1'b1;
                ram_raddr = pos_reg[AW-1:0];
            end
            ale_pkg::S_GETD:
                res_word_next = ram_rdata;
            // Reverse: read both ends, then write them back crossed.
            ale_pkg::S_REVA:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg[AW-1:0];
            end
            ale_pkg::S_REVB:
            begin
                ram_re    = 1'b1;
                ram_raddr = hi_reg[AW-1:0];
                prev_next = ram_rdata;
            end
            ale_pkg::S_REVC:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
            end
            ale_pkg::S_REVD:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg[AW-1:0];
                ram_wdata = prev_reg;
                idx_next  = idx_p1;
                hi_next   = hi_m1;
            end
            // Quotient sign follows the sum, as the count is positive.
            ale_pkg::S_DIVW:
            begin
                if (div_done)
                begin
                    res_word_next = acc_reg[WW-1] ? (~div_quot + WW'(1)) : div_quot;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register: loaded from the result staging when free.
    assign out_vld_next = (state_reg == ale_pkg::S_FIN && out_free) ? 1'b1
                        : (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ale_pkg::S_IDLE;
            cnt_reg     <= '0;
            cap_reg     <= CW'(ale_pkg::DEPTH);
            out_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            iss_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
            rd_vld_reg  <= rd_vld_next;
            iss_reg     <= iss_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        word_reg       <= word_next;
        idx_reg        <= idx_next;
        hi_reg         <= hi_next;
        rd_idx_reg     <= rd_idx_next;
        acc_reg        <= acc_next;
        prev_reg       <= prev_next;
        hit_reg        <= hit_next;
        res_word_reg   <= res_word_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (state_reg == ale_pkg::S_FIN && out_free)
        begin
            out_word_reg   <= res_word_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
            out_cnt_reg    <= cnt_reg;
        end
    end

    assign out_valid     = out_vld_reg;
    assign word_out      = out_word_reg;
    assign found_at      = out_found_reg;
    assign status        = out_status_reg;
    assign element_count = out_cnt_reg;

    // The live count never exceeds the store depth.
    `ALE_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(ale_pkg::DEPTH))
    // Every accepted command takes the sequencer out of the idle state in the next cycle.
    `ALE_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, state_reg != ale_pkg::S_IDLE)
    // The divider only finishes while the sequencer waits for it.
    `ALE_ASSERT_NOW(a_div_done, clk, rst_n, div_done, state_reg == ale_pkg::S_DIVW)

endmodule
